/* hdl/lvd_pkg.sv */
// Shared types, constants and helpers for the LEB128 varint decoder.
package lvd_pkg;

   // Value kinds, taken from the first byte of each value
   typedef enum logic [1:0] {
      LVD_KIND_U32 = 2'd0,
      LVD_KIND_U64 = 2'd1,
      LVD_KIND_S32 = 2'd2,
      LVD_KIND_S64 = 2'd3
   } lvd_kind_type;

   localparam logic [3:0] LVD_LIMIT_32     = 4'd5;
   localparam logic [3:0] LVD_LIMIT_64     = 4'd10;
   localparam int         LVD_CONT_BIT     = 7;
   localparam int         LVD_SIGN_BIT     = 6;
   localparam int         LVD_PAYLOAD_W    = 7;
   localparam int         LVD_QUEUE_DEPTH  = 2;

   // One classified word passed from the front to the back
   typedef struct packed {
      logic [LVD_PAYLOAD_W-1:0] payload;   // low 7 bits of the byte
      logic                     sign;      // bit 6 of the byte
      logic [3:0]               pos;       // byte position inside the value, 0..9
      lvd_kind_type             kind;      // latched kind of the value
      logic                     last;      // this word ends the value
      logic                     cont;      // continuation bit of the byte
   } lvd_entry_type;

   // Front tracking state exposed for checking
   typedef struct packed {
      logic [3:0] bytes_taken;
      logic       is32;
   } lvd_front_status_type;

   // Bit offset of a byte position: pos * 7
   function automatic logic [6:0] lvd_bit_offset(input logic [3:0] pos);
      logic [6:0] p;
      p = {3'd0, pos};
      return 7'((p << 3) - p);
   endfunction

   function automatic logic lvd_is32(input lvd_kind_type kind);
      return (kind == LVD_KIND_U32) || (kind == LVD_KIND_S32);
   endfunction

endpackage

/* hdl/lvd_front.sv */
// Front end: accepts input words, latches the kind and classifies value ends.
module lvd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic [1:0]                    req_operation,
   input  logic                          req_last_available,
   input  logic                          q_full,
   output logic                          q_push,
   output lvd_pkg::lvd_entry_type        q_entry,
   output lvd_pkg::lvd_front_status_type front_status
);
   import lvd_pkg::*;

   logic [3:0]   bytes_taken_ff, bytes_taken_in;
   lvd_kind_type kind_ff, kind_in;
   lvd_kind_type kind_cur;
   logic         is32;
   logic [3:0]   limit;
   logic [3:0]   count;
   logic         cont;
   logic         ends;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   // Pick the kind: new on the first byte, held otherwise
   assign kind_cur = (bytes_taken_ff == 4'd0) ? lvd_kind_type'(req_operation) : kind_ff;
   assign is32     = lvd_is32(kind_cur);
   assign limit    = is32 ? LVD_LIMIT_32 : LVD_LIMIT_64;
   assign count    = bytes_taken_ff + 4'd1;
   assign cont     = req_data_byte[LVD_CONT_BIT];
   assign ends     = !cont || (count >= limit) || req_last_available;

   // Build the classified word
   always_comb begin
      q_entry.payload = req_data_byte[LVD_PAYLOAD_W-1:0];
      q_entry.sign    = req_data_byte[LVD_SIGN_BIT];
      q_entry.pos     = bytes_taken_ff;
      q_entry.kind    = kind_cur;
      q_entry.last    = ends;
      q_entry.cont    = cont;
   end

   // Advance the byte count, clear it at a value end
   always_comb begin
      bytes_taken_in = bytes_taken_ff;
      kind_in        = kind_ff;
      if (q_push) begin
         kind_in        = kind_cur;
         bytes_taken_in = ends ? 4'd0 : count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_taken_ff <= 4'd0;
         kind_ff        <= LVD_KIND_U32;
      end else begin
         bytes_taken_ff <= bytes_taken_in;
         kind_ff        <= kind_in;
      end
   end

   assign front_status.bytes_taken = bytes_taken_ff;
   assign front_status.is32        = lvd_is32(kind_ff);

endmodule

/* hdl/lvd_queue.sv */
// Short queue of classified words between the front and the back.
module lvd_queue #(
   parameter int DEPTH = lvd_pkg::LVD_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lvd_pkg::lvd_entry_type push_entry,
   input  logic                   pop,
   output lvd_pkg::lvd_entry_type head_entry,
   output logic                   empty,
   output logic                   full
);
   import lvd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   lvd_entry_type    store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] level_ff, level_in;

   assign empty      = (level_ff == '0);
   assign full       = (level_ff == CNT_FULL);
   assign head_entry = store_ff[rd_ptr_ff];

   // Advance pointers and level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + CNT_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Write the entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hdl/lvd_back.sv */
// Back end: gathers payload bits, finishes values and holds the result register.
module lvd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lvd_pkg::lvd_entry_type head_entry,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [63:0]            rsp_value,
   output logic [3:0]             rsp_byte_count,
   output logic                   rsp_truncated
);
   import lvd_pkg::*;

   logic [63:0] acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] value_ff, value_in;
   logic [3:0]  count_ff, count_in;
   logic        trunc_ff, trunc_in;

   logic        out_free;
   logic        is32;
   logic [6:0]  shift;
   logic [6:0]  filled;
   logic [3:0]  count;
   logic [63:0] acc_sum;
   logic [63:0] ext_mask;
   logic [31:0] low32;
   logic [63:0] finished;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign q_pop    = !q_empty && (!head_entry.last || out_free);

   // Place the payload at its 7-bit position
   assign is32   = lvd_is32(head_entry.kind);
   assign shift  = lvd_bit_offset(head_entry.pos);
   assign count  = head_entry.pos + 4'd1;
   assign filled = lvd_bit_offset(count);

   always_comb begin
      acc_sum = acc_ff | ({57'd0, head_entry.payload} << shift[5:0]);
      if (shift[6]) begin
         acc_sum = acc_ff;
      end
      if (is32) begin
         acc_sum[63:32] = 32'd0;
      end
   end

   // Finish the value by kind
   assign ext_mask = {64{1'b1}} << filled;

   always_comb begin
      low32    = acc_sum[31:0];
      finished = acc_sum;
      unique case (head_entry.kind)
         LVD_KIND_U32: begin
            finished = {32'd0, acc_sum[31:0]};
         end
         LVD_KIND_U64: begin
            finished = acc_sum;
         end
         LVD_KIND_S32: begin
            if (head_entry.sign && (filled < 7'd32)) begin
               low32 = acc_sum[31:0] | ext_mask[31:0];
            end
            finished = {{32{low32[31]}}, low32};
         end
         default: begin
            if (head_entry.sign && (filled < 7'd64)) begin
               finished = acc_sum | ext_mask;
            end
         end
      endcase
   end

   // Advance the accumulator and load the result register
   always_comb begin
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      value_in     = value_ff;
      count_in     = count_ff;
      trunc_in     = trunc_ff;
      if (q_pop) begin
         if (head_entry.last) begin
            acc_in       = 64'd0;
            rsp_valid_in = 1'b1;
            value_in     = finished;
            count_in     = count;
            trunc_in     = head_entry.cont;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 64'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      count_ff <= count_in;
      trunc_ff <= trunc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = value_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_truncated  = trunc_ff;

endmodule

/* hdl/leb128_varint_decoder.sv */
// LEB128 decoder top level: one byte word per cycle while the queue has room.
// Throughput: one byte per cycle, sustained while results are taken; the back drains one queue word a cycle.
// A value's ending byte is stored in the queue, then the back loads the result register from it.
// The queue between front and back lets each side stall on its own; the result register
// takes a new value while the previous one is taken in the same cycle.
// Reset (synchronous, active high) empties the queue, drops any pending result and
// clears the partial value and byte count.
module leb128_varint_decoder #(
   parameter int QUEUE_DEPTH = lvd_pkg::LVD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic [1:0]  req_operation,
   input  logic        req_last_available,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_value,
   output logic [3:0]  rsp_byte_count,
   output logic        rsp_truncated
);
   import lvd_pkg::*;

   lvd_entry_type        push_entry;
   lvd_entry_type        head_entry;
   lvd_front_status_type front_status;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_empty;
   logic                 q_full;

   // Classify incoming words
   lvd_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_operation      (req_operation),
      .req_last_available (req_last_available),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_entry            (push_entry),
      .front_status       (front_status)
   );

   // Decouple front and back
   lvd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .empty      (q_empty),
      .full       (q_full)
   );

   // Gather and finish values
   lvd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_entry     (head_entry),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_byte_count (rsp_byte_count),
      .rsp_truncated  (rsp_truncated)
   );

   // The front never holds a count at or past the kind's byte limit
   a_front_below_limit: assert property (@(posedge clock) disable iff (reset)
      front_status.is32 ? (front_status.bytes_taken < LVD_LIMIT_32)
                        : (front_status.bytes_taken < LVD_LIMIT_64))
      else $error("front byte count reached the limit");

   // Every result reports one to ten bytes
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count != 4'd0) && (rsp_byte_count <= LVD_LIMIT_64))
      else $error("result byte count out of range");

   // No result right after reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // An empty queue never pops
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !q_pop)
      else $error("pop from empty queue");

endmodule
